>>> hw/rtl/shp_pkg.sv
// Shared types and constants of the shortest-hop path planner.
package shp_pkg;

	localparam int NODE_W = 5;
	localparam int DIST_W = 6;
	localparam int REQ_W  = 2;

	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	typedef struct packed {
		logic take;
		logic clear;
		logic add_rd_a;
		logic add_wr_a;
		logic add_rd_b;
		logic add_wr_b;
		logic init;
		logic row_issue;
		logic walk_step;
		logic emit;
	} shp_cmd_t;

	typedef struct packed {
		logic edge_ok;
		logic end_ok;
		logic pass_end;
		logic pass_changed;
		logic walk_more;
		logic emit_last;
	} shp_sts_t;

endpackage

>>> hw/rtl/shp_ctrl.sv
// Controller state machine of the shortest-hop path planner.
module shp_ctrl
	import shp_pkg::*;
#(
	parameter int NUM_VERTICES = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [REQ_W-1:0] req_type,
	input  shp_sts_t         sts,
	output logic             in_stall,
	output shp_cmd_t         cmd
);

	localparam int PW = (NUM_VERTICES > 2) ? $clog2(NUM_VERTICES - 1) : 1;
	localparam logic [PW-1:0] LAST_PASS = PW'(NUM_VERTICES - 2);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_ADD_RD_A = 4'd1;
	localparam logic [3:0] ST_ADD_WR_A = 4'd2;
	localparam logic [3:0] ST_ADD_RD_B = 4'd3;
	localparam logic [3:0] ST_ADD_WR_B = 4'd4;
	localparam logic [3:0] ST_INIT     = 4'd5;
	localparam logic [3:0] ST_RELAX    = 4'd6;
	localparam logic [3:0] ST_WALK     = 4'd7;
	localparam logic [3:0] ST_EMIT     = 4'd8;

	logic [3:0]    state_q;
	logic [3:0]    state_d;
	logic [PW-1:0] pass_q;
	logic          relax_done;

	assign in_stall   = (state_q != ST_IDLE);
	assign relax_done = sts.pass_end && (!sts.pass_changed || pass_q == LAST_PASS);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					unique case (req_type)
						REQ_ADD: begin
							if (sts.edge_ok) begin
								state_d = ST_ADD_RD_A;
							end
						end
						REQ_QUERY: begin
							state_d = sts.end_ok ? ST_INIT : ST_WALK;
						end
						REQ_CLEAR: begin
							cmd.clear = 1'b1;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_ADD_RD_A: begin
				cmd.add_rd_a = 1'b1;
				state_d      = ST_ADD_WR_A;
			end
			ST_ADD_WR_A: begin
				cmd.add_wr_a = 1'b1;
				state_d      = ST_ADD_RD_B;
			end
			ST_ADD_RD_B: begin
				cmd.add_rd_b = 1'b1;
				state_d      = ST_ADD_WR_B;
			end
			ST_ADD_WR_B: begin
				cmd.add_wr_b = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_RELAX;
			end
			ST_RELAX: begin
				// stop issuing rows once the pass that ends here is the final one
				cmd.row_issue = !relax_done;
				if (relax_done) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (!sts.walk_more) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) begin
				pass_q <= '0;
			end else if (state_q == ST_RELAX && sts.pass_end) begin
				pass_q <= pass_q + 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RELAX |-> pass_q <= LAST_PASS)
		else $error("pass count beyond the last pass");

	a_init_to_relax: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INIT |=> state_q == ST_RELAX)
		else $error("init not followed by relaxation");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && !sts.emit_last |=> state_q == ST_EMIT)
		else $error("emission left before the last node");
`endif

endmodule

>>> hw/rtl/shp_datapath.sv
// Datapath of the shortest-hop path planner: graph store, hop lanes, path buffer, output.
module shp_datapath
	import shp_pkg::*;
#(
	parameter int NUM_VERTICES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  shp_cmd_t          cmd,
	output shp_sts_t          sts,
	input  logic [NODE_W-1:0] node_a,
	input  logic [NODE_W-1:0] node_b,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [NODE_W-1:0] path_node,
	output logic              last
);

	localparam int NV       = NUM_VERTICES;
	localparam int VW       = $clog2(NV);
	localparam int XW       = (VW > NODE_W) ? VW : NODE_W;
	localparam int PATH_MAX = (NV < (1 << NODE_W)) ? NV : (1 << NODE_W);
	localparam int BW       = $clog2(PATH_MAX);
	localparam logic [NV-1:0] ROW_ONE  = {{(NV - 1){1'b0}}, 1'b1};
	localparam logic [VW-1:0] LAST_ROW = VW'(NV - 1);
	localparam logic [BW-1:0] LAST_POS = BW'(PATH_MAX - 1);

	// request operands
	logic [NODE_W-1:0] a_q;
	logic [NODE_W-1:0] b_q;
	logic [XW-1:0]     a_x;
	logic [XW-1:0]     b_x;
	logic [VW-1:0]     a_idx;
	logic [VW-1:0]     b_idx;
	logic              a_ok;

	// adjacency store
	logic [NV-1:0] adj_q [NV];
	logic [NV-1:0] adj_vld_q;
	logic [NV-1:0] adj_rd_s1;
	logic          adj_rv_s1;
	logic [NV-1:0] adj_row;
	logic          adj_re;
	logic          adj_we;
	logic [VW-1:0] adj_raddr;
	logic [VW-1:0] adj_waddr;
	logic [VW-1:0] adj_other;
	logic [NV-1:0] adj_wdata;

	// relaxation lanes
	logic [DIST_W-1:0] dist_q [NV];
	logic [VW-1:0]     par_q [NV];
	logic [NV-1:0]     reach_q;
	logic [NV-1:0]     pvld_q;
	logic [VW-1:0]     rd_idx_q;
	logic              row_vld_s1;
	logic [VW-1:0]     row_idx_s1;
	logic [DIST_W:0]   cand;
	logic [NV-1:0]     upd;
	logic              row_chg;
	logic              chg_q;

	// path walk and emission
	logic [NODE_W-1:0] cur_q;
	logic [BW-1:0]     cnt_q;
	logic [XW-1:0]     cur_x;
	logic [VW-1:0]     cur_idx;
	logic              cur_ok;
	logic [XW-1:0]     par_x;
	logic [NODE_W-1:0] pbuf_q [PATH_MAX];
	logic [NODE_W-1:0] pb_rd_s1;
	logic              rd_pend_s1;
	logic              emit_rd;
	logic              emit_load;
	logic              out_free;
	logic              out_valid_q;
	logic [NODE_W-1:0] path_node_q;
	logic              last_q;

	assign a_x   = XW'(a_q);
	assign b_x   = XW'(b_q);
	assign a_idx = a_x[VW-1:0];
	assign b_idx = b_x[VW-1:0];
	assign a_ok  = int'(a_q) < NV;

	assign sts.edge_ok = (int'(node_a) < NV) && (int'(node_b) < NV);
	assign sts.end_ok  = int'(node_b) < NV;

	// graph store: one row per vertex, rows not written since clear read as empty
	assign adj_re    = cmd.add_rd_a | cmd.add_rd_b | cmd.row_issue;
	assign adj_raddr = cmd.row_issue ? rd_idx_q : (cmd.add_rd_b ? b_idx : a_idx);
	assign adj_we    = cmd.add_wr_a | cmd.add_wr_b;
	assign adj_waddr = cmd.add_wr_b ? b_idx : a_idx;
	assign adj_other = cmd.add_wr_b ? a_idx : b_idx;
	assign adj_row   = adj_rv_s1 ? adj_rd_s1 : '0;
	assign adj_wdata = adj_row | (ROW_ONE << adj_other);

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_q[adj_waddr] <= adj_wdata;
		end
		if (adj_re) begin
			adj_rd_s1 <= adj_q[adj_raddr];
			adj_rv_s1 <= adj_vld_q[adj_raddr];
		end
	end

	// relax one row per cycle; every neighbor lane compares in parallel
	assign cand = {1'b0, dist_q[row_idx_s1]} + 1'b1;

	always_comb begin
		for (int j = 0; j < NV; j++) begin
			upd[j] = row_vld_s1 && reach_q[row_idx_s1] && adj_row[j]
				&& (!reach_q[j] || cand < {1'b0, dist_q[j]});
		end
	end

	assign row_chg          = |upd;
	assign sts.pass_end     = row_vld_s1 && (row_idx_s1 == LAST_ROW);
	assign sts.pass_changed = chg_q | row_chg;

	always_ff @(posedge clk) begin
		for (int j = 0; j < NV; j++) begin
			if (cmd.init) begin
				reach_q[j] <= a_ok && (a_idx == VW'(j));
				pvld_q[j]  <= 1'b0;
				if (a_ok && (a_idx == VW'(j))) begin
					dist_q[j] <= '0;
				end
			end else if (upd[j]) begin
				dist_q[j]  <= cand[DIST_W-1:0];
				reach_q[j] <= 1'b1;
				par_q[j]   <= row_idx_s1;
				pvld_q[j]  <= 1'b1;
			end
		end
		row_idx_s1 <= rd_idx_q;
	end

	// walk parents from the end node back to the start
	assign cur_x   = XW'(cur_q);
	assign cur_idx = cur_x[VW-1:0];
	assign cur_ok  = int'(cur_q) < NV;
	assign par_x   = XW'(par_q[cur_idx]);

	assign sts.walk_more = cur_ok && pvld_q[cur_idx] && (cnt_q != LAST_POS);

	// emit start first; one buffer read, then one load into the output register
	assign out_free      = !out_valid_q || !out_stall;
	assign emit_rd       = cmd.emit && !rd_pend_s1;
	assign emit_load     = cmd.emit && rd_pend_s1 && out_free;
	assign sts.emit_last = emit_load && (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.walk_step) begin
			pbuf_q[cnt_q] <= cur_q;
		end
		if (emit_rd) begin
			pb_rd_s1 <= pbuf_q[cnt_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			a_q   <= node_a;
			b_q   <= node_b;
			cur_q <= node_b;
			cnt_q <= '0;
		end else if (cmd.walk_step && sts.walk_more) begin
			cur_q <= par_x[NODE_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end else if (emit_load) begin
			cnt_q <= cnt_q - 1'b1;
		end
		if (emit_load) begin
			path_node_q <= pb_rd_s1;
			last_q      <= (cnt_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_vld_q   <= '0;
			rd_idx_q    <= '0;
			row_vld_s1  <= 1'b0;
			chg_q       <= 1'b0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				adj_vld_q <= '0;
			end else if (adj_we) begin
				adj_vld_q[adj_waddr] <= 1'b1;
			end

			if (cmd.init) begin
				rd_idx_q <= '0;
			end else if (cmd.row_issue) begin
				rd_idx_q <= (rd_idx_q == LAST_ROW) ? '0 : rd_idx_q + 1'b1;
			end
			row_vld_s1 <= cmd.row_issue;

			if (cmd.init || sts.pass_end) begin
				chg_q <= 1'b0;
			end else if (row_chg) begin
				chg_q <= 1'b1;
			end

			if (emit_rd) begin
				rd_pend_s1 <= 1'b1;
			end else if (emit_load) begin
				rd_pend_s1 <= 1'b0;
			end

			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign path_node = path_node_q;
	assign last      = last_q;

`ifndef SYNTH
	a_start_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		row_vld_s1 && a_ok |-> reach_q[a_idx] && dist_q[a_idx] == '0 && !pvld_q[a_idx])
		else $error("start vertex lost its zero distance or gained a parent");

	a_read_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> cmd.emit)
		else $error("path buffer read pending outside emission");
`endif

endmodule

>>> hw/rtl/shortest_hop_path_planner.sv
// Top level of the shortest-hop path planner: controller plus datapath.
// Add edge: taken, then a read-modify-write of both rows; an out-of-range node drops it.
// Clear graph: drops all row valid bits at once. Unknown request: taken and ignored.
// Query: an init step and a fill step, then relaxation passes of one adjacency row read
// per cycle, at most NUM_VERTICES-1 passes, then the parent walk and the emission of one
// node per output transfer; an out-of-range end node goes straight to the walk. Reset
// clears the graph and all control state; lane and buffer contents wait for a query.
module shortest_hop_path_planner
	import shp_pkg::*;
#(
	parameter int NUM_VERTICES = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [NODE_W-1:0] node_a,
	input  logic [NODE_W-1:0] node_b,
	// path channel, one node per transfer, start first
	output logic              out_valid,
	input  logic              out_stall,
	output logic [NODE_W-1:0] path_node,
	output logic              last
);

	// The controller sequences requests: it stalls the request channel while an
	// edge write, a relaxation or a path emission is in progress. A query walks
	// rows in ascending order and advances pass by pass until a pass changes no
	// distance or the pass limit is hit; the parent chain is then walked from the
	// end node into a buffer and read back in reverse.
	shp_cmd_t cmd;
	shp_sts_t sts;

	shp_ctrl #(
		.NUM_VERTICES(NUM_VERTICES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// The datapath holds the graph rows, the per-vertex hop and parent lanes,
	// the path buffer and the output register. The last node of a path can sit in
	// the output register while the next request transfers in.
	shp_datapath #(
		.NUM_VERTICES(NUM_VERTICES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.node_a    (node_a),
		.node_b    (node_b),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.path_node (path_node),
		.last      (last)
	);

endmodule
